@@ rtl/core/hsvc_pkg.sv @@
// hsvc_pkg: shared constants, widths, sector codes and the stage-load struct
// for the HSV to RGB pipeline. No dependencies.
package hsvc_pkg;

    // beat layout
    localparam int HUE_W    = 9;
    localparam int PCT_W    = 7;
    localparam int CHAN_W   = 8;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // hue decomposition: hue / 60 as (hue * 1093) >> 16, exact for 9-bit hue
    localparam int SECTOR_DEG   = 60;
    localparam int NUM_SECTORS  = 6;
    localparam int HUE_RECIP    = 1093;
    localparam int HUE_RECIP_SH = 16;
    localparam int HUE_PROD_W   = 20;
    localparam int QUO_W        = 4;
    localparam int HM_W         = 6;
    localparam int SECT_W       = 3;

    // sector codes
    localparam logic [SECT_W-1:0] SECT_RED_YEL = 3'd0;
    localparam logic [SECT_W-1:0] SECT_YEL_GRN = 3'd1;
    localparam logic [SECT_W-1:0] SECT_GRN_CYN = 3'd2;
    localparam logic [SECT_W-1:0] SECT_CYN_BLU = 3'd3;
    localparam logic [SECT_W-1:0] SECT_BLU_MAG = 3'd4;
    localparam logic [SECT_W-1:0] SECT_MAG_RED = 3'd5;

    // channel scaling: chan = floor(255*B*num / 600000), num <= 6000
    localparam int PCT_MAX    = 100;
    localparam int FULL_SCALE = 255;
    localparam int NUM_FULL   = SECTOR_DEG * PCT_MAX;            // 6000
    localparam int DIV_DEN    = SECTOR_DEG * PCT_MAX * PCT_MAX;  // 600000
    localparam int SCALED_W   = 15;   // 255*100
    localparam int NUM_W      = 13;   // 6000
    localparam int X_W        = SCALED_W + NUM_W;  // 153e6 fits in 28
    localparam int DIV_SHIFT  = 48;
    localparam longint unsigned DIV_RECIP =
        ((64'd1 << DIV_SHIFT) + 64'(DIV_DEN) - 64'd1) / 64'(DIV_DEN);
    localparam int RECIP_W    = 29;
    localparam int PROD_W     = X_W + RECIP_W;

    // channel lanes
    localparam int NUM_LANES = 4;
    localparam int LANE_V = 0;
    localparam int LANE_P = 1;
    localparam int LANE_Q = 2;
    localparam int LANE_T = 3;

    // per-stage load enables
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
        logic ld5;
        logic ld6;
    } t_stage_en;

    function automatic logic [PCT_W-1:0] pct_clamp(input logic [PCT_W-1:0] x);
        pct_clamp = (x > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : x;
    endfunction

endpackage

@@ rtl/core/hsvc_hue_split.sv @@
// hsvc_hue_split: stages 1-2, hue into sector and offset within sector.
// Depends on hsvc_pkg.
module hsvc_hue_split
    import hsvc_pkg::*;
(
    input  logic              i_clk,
    input  t_stage_en         i_en,
    input  logic [HUE_W-1:0]  i_hue,
    output logic [HM_W-1:0]   o_hm,
    output logic [SECT_W-1:0] o_sector
);

    logic [HUE_W-1:0]      r_hue;
    logic [QUO_W-1:0]      r_quo;
    logic [HUE_PROD_W-1:0] n_prod;
    logic [HUE_W-1:0]      n_rem;
    logic [HM_W-1:0]       r_hm;
    logic [SECT_W-1:0]     r_sector;
    logic [SECT_W-1:0]     n_sector;

    // stage 1: quotient by reciprocal
    assign n_prod = HUE_PROD_W'(i_hue) * HUE_PROD_W'(HUE_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en.ld1) begin
            r_hue <= i_hue;
            r_quo <= n_prod[HUE_RECIP_SH +: QUO_W];
        end
    end

    // stage 2: remainder and quotient mod 6 (quotient never above 8)
    assign n_rem    = r_hue - HUE_W'(r_quo) * HUE_W'(SECTOR_DEG);
    assign n_sector = (r_quo >= QUO_W'(NUM_SECTORS)) ?
                      SECT_W'(r_quo - QUO_W'(NUM_SECTORS)) : SECT_W'(r_quo);

    always_ff @(posedge i_clk) begin
        if (i_en.ld2) begin
            r_hm     <= n_rem[HM_W-1:0];
            r_sector <= n_sector;
        end
    end

    assign o_hm     = r_hm;
    assign o_sector = r_sector;

endmodule

@@ rtl/core/hsvc_numer.sv @@
// hsvc_numer: stages 1-3, clamps S and B, forms 255*B and the four
// numerators over 600000 for v, p, q and t. Depends on hsvc_pkg.
module hsvc_numer
    import hsvc_pkg::*;
(
    input  logic                 i_clk,
    input  t_stage_en            i_en,
    input  logic [PCT_W-1:0]     i_saturation,
    input  logic [PCT_W-1:0]     i_brightness,
    input  logic [HM_W-1:0]      i_hm,       // stage 2 output of hue split
    output logic [SCALED_W-1:0]  o_scaled,
    output logic [NUM_W-1:0]     o_num [NUM_LANES]
);

    logic [PCT_W-1:0]    n_s, n_b;
    logic [PCT_W-1:0]    r_s1, r_s2;
    logic [SCALED_W-1:0] r_scaled1, r_scaled2, r_scaled3;
    logic [NUM_W-1:0]    r_nump1, r_nump2;
    logic [NUM_W-1:0]    n_hms;
    logic [NUM_W-1:0]    r_num [NUM_LANES];

    assign n_s = pct_clamp(i_saturation);
    assign n_b = pct_clamp(i_brightness);

    // stage 1
    always_ff @(posedge i_clk) begin
        if (i_en.ld1) begin
            r_s1      <= n_s;
            r_scaled1 <= SCALED_W'(FULL_SCALE) * SCALED_W'(n_b);
            r_nump1   <= NUM_W'(NUM_FULL) - NUM_W'(SECTOR_DEG) * NUM_W'(n_s);
        end
    end

    // stage 2: align with hue offset
    always_ff @(posedge i_clk) begin
        if (i_en.ld2) begin
            r_s2      <= r_s1;
            r_scaled2 <= r_scaled1;
            r_nump2   <= r_nump1;
        end
    end

    // stage 3: hm*S, then q = 6000 - hm*S, t = 6000 - 60S + hm*S
    assign n_hms = NUM_W'(i_hm) * NUM_W'(r_s2);

    always_ff @(posedge i_clk) begin
        if (i_en.ld3) begin
            r_scaled3     <= r_scaled2;
            r_num[LANE_V] <= NUM_W'(NUM_FULL);
            r_num[LANE_P] <= r_nump2;
            r_num[LANE_Q] <= NUM_W'(NUM_FULL) - n_hms;
            r_num[LANE_T] <= r_nump2 + n_hms;
        end
    end

    assign o_scaled = r_scaled3;
    assign o_num    = r_num;

endmodule

@@ rtl/core/hsvc_lane_div.sv @@
// hsvc_lane_div: stages 4-5 of one channel lane, floor(scaled*num/600000)
// by an exact reciprocal multiply. Depends on hsvc_pkg.
module hsvc_lane_div
    import hsvc_pkg::*;
(
    input  logic                i_clk,
    input  t_stage_en           i_en,
    input  logic [SCALED_W-1:0] i_scaled,
    input  logic [NUM_W-1:0]    i_num,
    output logic [CHAN_W-1:0]   o_chan
);

    logic [X_W-1:0]    r_x;
    logic [PROD_W-1:0] n_prod;
    logic [CHAN_W-1:0] r_chan;

    // stage 4
    always_ff @(posedge i_clk) begin
        if (i_en.ld4) begin
            r_x <= X_W'(i_scaled) * X_W'(i_num);
        end
    end

    // stage 5: x < 2^28 and rounding error of the reciprocal < 2^20 keep it exact
    assign n_prod = PROD_W'(r_x) * PROD_W'(DIV_RECIP[RECIP_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_en.ld5) begin
            r_chan <= n_prod[DIV_SHIFT +: CHAN_W];
        end
    end

    assign o_chan = r_chan;

endmodule

@@ rtl/core/hsv_to_rgb_converter.sv @@
// hsv_to_rgb_converter: hue/saturation/brightness beat in, 8-bit RGB beat out.
// Throughput one beat per cycle while m_axis_tready is high, set by the
// six-stage pipeline with a valid bit per stage.
// Stalls back up stage by stage; bubbles are squeezed out under backpressure.
// Reset (i_rst_n, synchronous, active low) clears only the stage valid bits.
// Depends on hsvc_pkg, hsvc_hue_split, hsvc_numer, hsvc_lane_div.
module hsv_to_rgb_converter
    import hsvc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [8:0] hue, [15:9] saturation, [22:16] brightness, [23] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int NUM_STAGES = 6;

    // Stage map:
    //   1: clamp S/B, 255*B, 6000-60S, hue quotient by reciprocal
    //   2: hue offset hm and sector
    //   3: hm*S and the q/t numerators
    //   4: 255*B times each numerator (four lanes)
    //   5: reciprocal divide by 600000 per lane
    //   6: sector mux into the output register

    logic [HUE_W-1:0]    w_hue;
    logic [PCT_W-1:0]    w_sat, w_bri;
    logic [HM_W-1:0]     w_hm;
    logic [SECT_W-1:0]   w_sector2;
    logic [SCALED_W-1:0] w_scaled;
    logic [NUM_W-1:0]    w_num [NUM_LANES];
    logic [CHAN_W-1:0]   w_chan [NUM_LANES];

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] w_ready;
    t_stage_en             w_en;

    logic [SECT_W-1:0]     r_sector3, r_sector4, r_sector5;
    logic [CHAN_W-1:0]     r_red, r_green, r_blue;
    logic [CHAN_W-1:0]     n_red, n_green, n_blue;

    assign w_hue = s_axis_tdata[HUE_W-1:0];
    assign w_sat = s_axis_tdata[HUE_W +: PCT_W];
    assign w_bri = s_axis_tdata[HUE_W+PCT_W +: PCT_W];

    // ---------------------------------------------------------------
    // Pipeline control: a stage takes a new beat when it is empty or
    // its contents move on in the same cycle.
    // ---------------------------------------------------------------
    always_comb begin
        w_ready[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || m_axis_tready;
        for (int k = NUM_STAGES-2; k >= 0; k--) begin
            w_ready[k] = !r_valid[k] || w_ready[k+1];
        end
    end

    assign w_en.ld1 = w_ready[0];
    assign w_en.ld2 = w_ready[1];
    assign w_en.ld3 = w_ready[2];
    assign w_en.ld4 = w_ready[3];
    assign w_en.ld5 = w_ready[4];
    assign w_en.ld6 = w_ready[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_ready[0]) begin
                r_valid[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_ready[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    assign s_axis_tready = w_ready[0];
    assign m_axis_tvalid = r_valid[NUM_STAGES-1];

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    hsvc_hue_split u_hue_split (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_hue    (w_hue),
        .o_hm     (w_hm),
        .o_sector (w_sector2)
    );

    hsvc_numer u_numer (
        .i_clk        (i_clk),
        .i_en         (w_en),
        .i_saturation (w_sat),
        .i_brightness (w_bri),
        .i_hm         (w_hm),
        .o_scaled     (w_scaled),
        .o_num        (w_num)
    );

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        hsvc_lane_div u_lane_div (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_scaled (w_scaled),
            .i_num    (w_num[g]),
            .o_chan   (w_chan[g])
        );
    end

    // sector rides along with the lanes
    always_ff @(posedge i_clk) begin
        if (w_en.ld3) begin
            r_sector3 <= w_sector2;
        end
        if (w_en.ld4) begin
            r_sector4 <= r_sector3;
        end
        if (w_en.ld5) begin
            r_sector5 <= r_sector4;
        end
    end

    // stage 6: pick (v,p,q,t) per sector
    always_comb begin
        case (r_sector5)
            SECT_RED_YEL: begin
                n_red = w_chan[LANE_V]; n_green = w_chan[LANE_T]; n_blue = w_chan[LANE_P];
            end
            SECT_YEL_GRN: begin
                n_red = w_chan[LANE_Q]; n_green = w_chan[LANE_V]; n_blue = w_chan[LANE_P];
            end
            SECT_GRN_CYN: begin
                n_red = w_chan[LANE_P]; n_green = w_chan[LANE_V]; n_blue = w_chan[LANE_T];
            end
            SECT_CYN_BLU: begin
                n_red = w_chan[LANE_P]; n_green = w_chan[LANE_Q]; n_blue = w_chan[LANE_V];
            end
            SECT_BLU_MAG: begin
                n_red = w_chan[LANE_T]; n_green = w_chan[LANE_P]; n_blue = w_chan[LANE_V];
            end
            default: begin  // magenta to red
                n_red = w_chan[LANE_V]; n_green = w_chan[LANE_P]; n_blue = w_chan[LANE_Q];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en.ld6) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign m_axis_tdata = {r_blue, r_green, r_red};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------

    // a full pipeline with a stalled output must refuse input
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_valid) && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while pipeline full and stalled");

    // hue reciprocal must give a valid sector and offset
    a_hue_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[1] |-> (w_sector2 < SECT_W'(NUM_SECTORS)) && (w_hm < HM_W'(SECTOR_DEG)))
        else $error("hue split out of range");

    // q and t numerators never exceed full scale
    a_num_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[2] |-> (w_num[LANE_Q] <= NUM_W'(NUM_FULL)) &&
                       (w_num[LANE_T] <= NUM_W'(NUM_FULL)))
        else $error("channel numerator above full scale");

    // stage 5 holding a beat it cannot pass on keeps it
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[NUM_STAGES-2] && !w_ready[NUM_STAGES-1] |=> r_valid[NUM_STAGES-2])
        else $error("beat lost in stage 5 under stall");

endmodule

@@ bench/hsv_to_rgb_converter_chk.sv @@
`timescale 1ns / 100ps
// hsv_to_rgb_converter_chk: watches both stream ports of the HSV to RGB converter,
// predicts each RGB beat from the accepted HSV beat and compares in order.
// Depends on hsvc_pkg for beat widths, scaling constants and sector codes.
module hsv_to_rgb_converter_chk
    import hsvc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_tvalid,
    input  logic                   i_in_tready,
    // [8:0] hue, [15:9] saturation, [22:16] brightness, [23] zero
    input  logic [IN_TDATA_W-1:0]  i_in_tdata,
    input  logic                   i_out_tvalid,
    input  logic                   i_out_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    input  logic [OUT_TDATA_W-1:0] i_out_tdata,
    output int                     o_err_count = 0,
    output int                     o_pending = 0
);

    // blue on top so the struct lines up with the output tdata layout
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_rgb;

    typedef struct {
        logic [IN_TDATA_W-1:0] hsv;
        t_rgb                  rgb;
    } t_rgb_due;

    t_rgb_due rgb_due_q[$];
    int       fault_count = 0;

    // exact integer floors; out-of-range percentages saturate at 100
    function automatic t_rgb rgb_from_hsv(input logic [IN_TDATA_W-1:0] beat);
        int unsigned hue, sat, bri, hm, scaled, v, p, q, t;
        t_rgb        c;
        hue = beat[HUE_W-1:0];
        sat = beat[HUE_W +: PCT_W];
        bri = beat[HUE_W+PCT_W +: PCT_W];
        if (sat > PCT_MAX) sat = PCT_MAX;
        if (bri > PCT_MAX) bri = PCT_MAX;
        hm     = hue % SECTOR_DEG;
        scaled = FULL_SCALE * bri;
        v = scaled / PCT_MAX;
        p = scaled * (PCT_MAX - sat) / (PCT_MAX * PCT_MAX);
        q = scaled * (NUM_FULL - hm * sat) / DIV_DEN;
        t = scaled * (NUM_FULL - (SECTOR_DEG - hm) * sat) / DIV_DEN;
        // hue 360 and above wraps through the mod, no clamping
        case (SECT_W'((hue / SECTOR_DEG) % NUM_SECTORS))
            SECT_RED_YEL: begin c.red = CHAN_W'(v); c.green = CHAN_W'(t); c.blue = CHAN_W'(p); end
            SECT_YEL_GRN: begin c.red = CHAN_W'(q); c.green = CHAN_W'(v); c.blue = CHAN_W'(p); end
            SECT_GRN_CYN: begin c.red = CHAN_W'(p); c.green = CHAN_W'(v); c.blue = CHAN_W'(t); end
            SECT_CYN_BLU: begin c.red = CHAN_W'(p); c.green = CHAN_W'(q); c.blue = CHAN_W'(v); end
            SECT_BLU_MAG: begin c.red = CHAN_W'(t); c.green = CHAN_W'(p); c.blue = CHAN_W'(v); end
            default: begin c.red = CHAN_W'(v); c.green = CHAN_W'(p); c.blue = CHAN_W'(q); end
        endcase
        return c;
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    // pop before push: a beat leaving this cycle never matches one entering it
    always @(posedge i_clk) begin : watch
        t_rgb     got;
        t_rgb_due due;
        if (i_rst_n) begin
            if (i_out_tvalid && i_out_tready) begin
                got = t_rgb'(i_out_tdata);
                if (rgb_due_q.size() == 0) begin
                    note_fault($sformatf("unexpected RGB beat r=%0d g=%0d b=%0d",
                                         got.red, got.green, got.blue));
                end else begin
                    due = rgb_due_q.pop_front();
                    if (got.red !== due.rgb.red || got.green !== due.rgb.green ||
                        got.blue !== due.rgb.blue)
                        note_fault($sformatf(
                            "hsv h=%0d s=%0d v=%0d: want r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                            due.hsv[HUE_W-1:0], due.hsv[HUE_W +: PCT_W],
                            due.hsv[HUE_W+PCT_W +: PCT_W],
                            due.rgb.red, due.rgb.green, due.rgb.blue,
                            got.red, got.green, got.blue));
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                due.hsv = i_in_tdata;
                due.rgb = rgb_from_hsv(i_in_tdata);
                rgb_due_q.push_back(due);
            end
        end
        o_pending   <= rgb_due_q.size();
        o_err_count <= fault_count;
    end

endmodule

@@ bench/hsv_to_rgb_converter_tb.sv @@
`timescale 1ns / 100ps
// hsv_to_rgb_converter_tb: drives HSV beats into the converter under random
// source gaps and sink backpressure; checking lives in hsv_to_rgb_converter_chk.
// Depends on hsvc_pkg, hsv_to_rgb_converter and hsv_to_rgb_converter_chk.
module hsv_to_rgb_converter_tb;
    import hsvc_pkg::*;

    localparam int RANDOM_BEATS = 750;
    localparam int SINK_HOLD    = 64;   // long enough to fill the six stages
    localparam int HOLD_AT_BEAT = 100;  // output beat count that triggers the hold
    localparam int DRAIN_CYCLES = 16;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [8:0] hue, [15:9] saturation, [22:16] brightness, [23] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [7:0] red, [15:8] green, [23:16] blue
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int err_count;
    int pending;
    bit calm = 1'b0;  // no idling on either side while set

    always #5 i_clk = ~i_clk;

    hsv_to_rgb_converter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    hsv_to_rgb_converter_chk i_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .o_err_count  (err_count),
        .o_pending    (pending)
    );

    // Offer one beat, with random idle cycles ahead of it; returns at the
    // edge that took it, leaving tvalid high for back-to-back beats.
    task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [PCT_W-1:0] sat,
                              input logic [PCT_W-1:0] bri);
        while (!calm && $urandom_range(99) < 32) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, bri, sat, hue};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Sink: random ready, plus one long hold-off once output traffic is
    // flowing. The source keeps offering, so the pipe fills and tready drops.
    initial begin : sink
        int taken;
        taken = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                taken++;
                if (taken == HOLD_AT_BEAT) begin
                    m_axis_tready <= 1'b0;
                    repeat (SINK_HOLD) @(posedge i_clk);
                end
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 32);
        end
    end

    initial begin : source
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat, bri;
        int               pick;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: primaries and secondaries at full scale, sector edges,
        // hue 360 wrap, hue past 360, clamped percentages, gray and black
        send_pixel(0, 0, 0);
        send_pixel(0, 100, 100);
        send_pixel(60, 100, 100);
        send_pixel(120, 100, 100);
        send_pixel(180, 100, 100);
        send_pixel(240, 100, 100);
        send_pixel(300, 100, 100);
        send_pixel(360, 100, 100);
        send_pixel(359, 100, 100);
        send_pixel(59, 100, 100);
        send_pixel(61, 37, 83);
        send_pixel(210, 50, 50);
        send_pixel(330, 75, 100);
        send_pixel(90, 0, 100);
        send_pixel(45, 100, 0);
        send_pixel(30, 127, 100);
        send_pixel(150, 100, 127);
        send_pixel(420, 100, 100);
        send_pixel(479, 60, 90);
        send_pixel(511, 127, 127);
        send_pixel(256, 64, 64);
        send_pixel(1, 1, 1);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == 260) calm <= 1'b1;
            if (n == 400) calm <= 1'b0;
            // source pause: let the pipe drain completely, then resume;
            // one edge first so the count includes the last beat taken
            if (n == 500) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                wait (pending == 0);
                @(posedge i_clk);
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                hue = HUE_W'($urandom_range(360));
                sat = PCT_W'($urandom_range(PCT_MAX));
                bri = PCT_W'($urandom_range(PCT_MAX));
            end else if (pick < 82) begin
                // sector boundaries with saturation at the ends and brightness full or random
                hue = HUE_W'(SECTOR_DEG * $urandom_range(NUM_SECTORS));
                case ($urandom_range(2))
                    0: hue = hue;
                    1: hue = hue + 1'b1;
                    default: hue = hue + HUE_W'(SECTOR_DEG - 1);
                endcase
                sat = $urandom_range(1) ? PCT_W'(PCT_MAX) : '0;
                bri = $urandom_range(1) ? PCT_W'(PCT_MAX) : PCT_W'($urandom_range(PCT_MAX));
            end else begin
                // full field width, out-of-range values included
                {bri, sat, hue} = (HUE_W + 2 * PCT_W)'($urandom);
            end
            send_pixel(hue, sat, bri);
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/hsvc_pkg.sv
rtl/core/hsvc_hue_split.sv
rtl/core/hsvc_numer.sv
rtl/core/hsvc_lane_div.sv
rtl/core/hsv_to_rgb_converter.sv
bench/hsv_to_rgb_converter_chk.sv
bench/hsv_to_rgb_converter_tb.sv
